@@ rtl/core/range_kth_smallest_engine_core_defines.svh @@
// Assertion helpers shared by the core RTL.
`ifndef RANGE_KTH_SMALLEST_ENGINE_CORE_DEFINES_SVH
`define RANGE_KTH_SMALLEST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RKSE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rkse assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RKSE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rkse assertion failed");

`endif

@@ rtl/core/rkse_pkg.sv @@
package rkse_pkg;

    localparam int OP_W     = 1;
    localparam int VALUE_W  = 10;
    localparam int POS_W    = 11;
    localparam int STATUS_W = 2;

    localparam int VALUE_LSB = 0;
    localparam int LEFT_LSB  = VALUE_LSB + VALUE_W;
    localparam int RIGHT_LSB = LEFT_LSB + POS_W;
    localparam int K_LSB     = RIGHT_LSB + POS_W;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND,
        OP_QUERY
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_QUERY,
        ST_FULL
    } status_t;

endpackage

@@ rtl/core/range_kth_smallest_engine_core.sv @@
// Persistent count tree over values 0..VALUE_RANGE-1 with k-th smallest range queries.
// Each input transaction gives exactly one result transaction. One item is worked on at
// a time; the next input is taken while the previous result waits on the master side.
// An append makes one pass to size the path and one to walk and write it, with one node
// memory read per level; in a query a step to the right child costs an extra node read.
// Bad queries and appends to a store holding MAX_ITEMS go straight to the result.
// The node pool and version table are not cleared after reset: node 0 and version 0 read
// as the empty tree, and every other entry is written before it can be read.
`include "range_kth_smallest_engine_core_defines.svh"

module range_kth_smallest_engine_core #(
    parameter int MAX_ITEMS   = 1024,
    parameter int VALUE_RANGE = 1024,
    parameter int NODE_POOL   = 16384
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rkse_pkg::S_DATA_W-1:0]  s_tdata,   // value, left, right, k
    input  logic [rkse_pkg::OP_W-1:0]      s_tuser,   // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rkse_pkg::M_DATA_W-1:0]  m_tdata,   // kth_value
    output logic [rkse_pkg::STATUS_W-1:0]  m_tuser    // status
);
    import rkse_pkg::*;

    localparam int NW = $clog2(NODE_POOL);
    localparam int FW = $clog2(NODE_POOL + 1);
    localparam int TW = $clog2(MAX_ITEMS + 1);
    localparam int VW = $clog2(VALUE_RANGE);
    localparam int DW = $clog2(VW + 2);
    localparam int CW = (TW > POS_W) ? TW : POS_W;
    localparam int SW = (VW > VALUE_W) ? VW : VALUE_W;
    localparam logic [VW-1:0] VHI = VW'(VALUE_RANGE - 1);

    typedef struct packed {
        logic [NW-1:0] lnk_l;
        logic [NW-1:0] lnk_r;
        logic [TW-1:0] tally;
    } node_t;

    typedef enum logic [3:0] {
        IDLE,
        APP_COUNT,
        APP_ROOT,
        APP_WALK,
        QRY_ROOT_A,
        QRY_ROOT_B,
        QRY_ROOT_C,
        QRY_NODE,
        QRY_CHILD,
        QRY_CMP,
        FINISH
    } state_t;

    // registers
    state_t             state_reg, state_next;
    logic [FW-1:0]      free_reg, free_next;
    logic [TW-1:0]      total_reg, total_next;
    logic [VW-1:0]      lo_reg, lo_next;
    logic [VW-1:0]      hi_reg, hi_next;
    logic [VW-1:0]      val_reg, val_next;
    logic [DW-1:0]      need_reg, need_next;
    logic [NW-1:0]      old_reg, old_next;
    logic [NW-1:0]      cur_reg, cur_next;
    logic [TW-1:0]      k_reg, k_next;
    logic [TW-1:0]      left_reg, left_next;
    logic [TW-1:0]      right_reg, right_next;
    logic [NW-1:0]      a_reg, a_next;
    logic [NW-1:0]      b_reg, b_next;
    logic [NW-1:0]      ar_reg, ar_next;
    logic [NW-1:0]      br_reg, br_next;
    logic [VW-1:0]      res_val_reg, res_val_next;
    status_t            res_st_reg, res_st_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;

    // memories
    node_t              node_mem [NODE_POOL];
    node_t              node_rd_a_reg, node_rd_b_reg;
    logic               zero_a_reg, zero_b_reg;
    logic [NW-1:0]      ver_mem [MAX_ITEMS + 1];
    logic [NW-1:0]      ver_rd_reg;
    logic               ver_zero_reg;

    logic               node_we;
    logic [NW-1:0]      node_waddr;
    node_t              node_wdata;
    logic [NW-1:0]      node_raddr_a, node_raddr_b;
    logic               ver_we;
    logic [TW-1:0]      ver_waddr;
    logic [NW-1:0]      ver_wdata;
    logic [TW-1:0]      ver_raddr;

    // datapath helpers
    node_t              nd_a, nd_b;
    logic [NW-1:0]      ver_q;
    logic [VW-1:0]      mid;
    logic [VW-1:0]      mid_up;
    logic [TW-1:0]      cnt;
    logic [SW-1:0]      in_val_ext;
    logic [VW-1:0]      in_val_sat;
    logic [CW-1:0]      q_left, q_right, q_k, q_total;
    logic               q_bad;
    logic               pool_short;
    logic [SW-1:0]      res_ext;
    logic               s_fire;

    assign nd_a   = zero_a_reg ? node_t'('0) : node_rd_a_reg;
    assign nd_b   = zero_b_reg ? node_t'('0) : node_rd_b_reg;
    assign ver_q  = ver_zero_reg ? '0 : ver_rd_reg;
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_up = mid + VW'(1);
    assign cnt    = nd_b.tally - nd_a.tally;

    assign in_val_ext = SW'(s_tdata[VALUE_LSB +: VALUE_W]);
    assign in_val_sat = (in_val_ext > SW'(VALUE_RANGE - 1)) ? VHI : in_val_ext[VW-1:0];

    assign q_left  = CW'(s_tdata[LEFT_LSB +: POS_W]);
    assign q_right = CW'(s_tdata[RIGHT_LSB +: POS_W]);
    assign q_k     = CW'(s_tdata[K_LSB +: POS_W]);
    assign q_total = CW'(total_reg);
    assign q_bad   = (q_left > q_right) || (q_right > q_total) || (q_k == '0)
                  || (q_k > (q_right - q_left));

    assign pool_short = ((FW+1)'(free_reg) + (FW+1)'(need_reg)) > (FW+1)'(NODE_POOL);

    assign res_ext = SW'(res_val_reg);
    assign s_fire  = s_tvalid && s_tready;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        state_next    = state_reg;
        free_next     = free_reg;
        total_next    = total_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        val_next      = val_reg;
        need_next     = need_reg;
        old_next      = old_reg;
        cur_next      = cur_reg;
        k_next        = k_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        ar_next       = ar_reg;
        br_next       = br_reg;
        res_val_next  = res_val_reg;
        res_st_next   = res_st_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        node_we      = 1'b0;
        node_waddr   = cur_reg;
        node_wdata   = '0;
        node_raddr_a = old_reg;
        node_raddr_b = b_reg;
        ver_we       = 1'b0;
        ver_waddr    = total_reg + TW'(1);
        ver_wdata    = free_reg[NW-1:0];
        ver_raddr    = total_reg;

        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    res_val_next = '0;
                    lo_next      = '0;
                    hi_next      = VHI;
                    if (op_t'(s_tuser) == OP_APPEND)
                    begin
                        val_next  = in_val_sat;
                        need_next = DW'(1);
                        if (total_reg >= TW'(MAX_ITEMS))
                        begin
                            res_st_next = ST_FULL;
                            state_next  = FINISH;
                        end
                        else
                        begin
                            state_next = APP_COUNT;
                        end
                    end
                    else if (q_bad)
                    begin
                        res_st_next = ST_BAD_QUERY;
                        state_next  = FINISH;
                    end
                    else
                    begin
                        k_next     = q_k[TW-1:0];
                        left_next  = q_left[TW-1:0];
                        right_next = q_right[TW-1:0];
                        state_next = QRY_ROOT_A;
                    end
                end
            end

            // size the path while the previous root is read
            APP_COUNT:
            begin
                if (lo_reg < hi_reg)
                begin
                    if (val_reg <= mid)
                        hi_next = mid;
                    else
                        lo_next = mid_up;
                    need_next = need_reg + DW'(1);
                end
                else if (pool_short)
                begin
                    res_st_next = ST_FULL;
                    state_next  = FINISH;
                end
                else
                begin
                    ver_we     = 1'b1;
                    old_next   = ver_q;
                    cur_next   = free_reg[NW-1:0];
                    lo_next    = '0;
                    hi_next    = VHI;
                    state_next = APP_ROOT;
                end
            end

            APP_ROOT:
            begin
                node_raddr_a = old_reg;
                state_next   = APP_WALK;
            end

            // copy one path node per cycle, read the next old node alongside
            APP_WALK:
            begin
                node_we          = 1'b1;
                node_wdata.tally = nd_a.tally + TW'(1);
                if (lo_reg >= hi_reg)
                begin
                    total_next  = total_reg + TW'(1);
                    free_next   = free_reg + FW'(need_reg);
                    res_st_next = ST_OK;
                    state_next  = FINISH;
                end
                else
                begin
                    if (val_reg <= mid)
                    begin
                        node_wdata.lnk_l = cur_reg + NW'(1);
                        node_wdata.lnk_r = nd_a.lnk_r;
                        node_raddr_a     = nd_a.lnk_l;
                        old_next         = nd_a.lnk_l;
                        hi_next          = mid;
                    end
                    else
                    begin
                        node_wdata.lnk_l = nd_a.lnk_l;
                        node_wdata.lnk_r = cur_reg + NW'(1);
                        node_raddr_a     = nd_a.lnk_r;
                        old_next         = nd_a.lnk_r;
                        lo_next          = mid_up;
                    end
                    cur_next = cur_reg + NW'(1);
                end
            end

            QRY_ROOT_A:
            begin
                ver_raddr  = left_reg;
                state_next = QRY_ROOT_B;
            end

            QRY_ROOT_B:
            begin
                ver_raddr  = right_reg;
                a_next     = ver_q;
                state_next = QRY_ROOT_C;
            end

            QRY_ROOT_C:
            begin
                b_next     = ver_q;
                state_next = QRY_NODE;
            end

            QRY_NODE:
            begin
                node_raddr_a = a_reg;
                node_raddr_b = b_reg;
                state_next   = QRY_CHILD;
            end

            // current nodes in hand: keep right links, fetch left children
            QRY_CHILD:
            begin
                ar_next      = nd_a.lnk_r;
                br_next      = nd_b.lnk_r;
                node_raddr_a = nd_a.lnk_l;
                node_raddr_b = nd_b.lnk_l;
                state_next   = QRY_CMP;
            end

            // left children in hand: tally difference decides the side
            QRY_CMP:
            begin
                if (cnt >= k_reg)
                begin
                    hi_next = mid;
                    if (lo_reg >= mid)
                    begin
                        res_val_next = lo_reg;
                        res_st_next  = ST_OK;
                        state_next   = FINISH;
                    end
                    else
                    begin
                        ar_next      = nd_a.lnk_r;
                        br_next      = nd_b.lnk_r;
                        node_raddr_a = nd_a.lnk_l;
                        node_raddr_b = nd_b.lnk_l;
                    end
                end
                else
                begin
                    k_next  = k_reg - cnt;
                    lo_next = mid_up;
                    if (mid_up >= hi_reg)
                    begin
                        res_val_next = mid_up;
                        res_st_next  = ST_OK;
                        state_next   = FINISH;
                    end
                    else
                    begin
                        node_raddr_a = ar_reg;
                        node_raddr_b = br_reg;
                        state_next   = QRY_CHILD;
                    end
                end
            end

            FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'(res_ext[VALUE_W-1:0]);
                    m_tuser_next  = res_st_reg;
                    state_next    = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            free_reg     <= FW'(1);
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            free_reg     <= free_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        val_reg     <= val_next;
        need_reg    <= need_next;
        old_reg     <= old_next;
        cur_reg     <= cur_next;
        k_reg       <= k_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        ar_reg      <= ar_next;
        br_reg      <= br_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
    end

    // node pool: one write, two reads; node 0 is the empty tree and reads as zero
    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        node_rd_a_reg <= node_mem[node_raddr_a];
        node_rd_b_reg <= node_mem[node_raddr_b];
        zero_a_reg    <= (node_raddr_a == '0);
        zero_b_reg    <= (node_raddr_b == '0);
    end

    // version roots: version 0 reads as node 0
    always_ff @(posedge clk)
    begin
        if (ver_we)
            ver_mem[ver_waddr] <= ver_wdata;
        ver_rd_reg   <= ver_mem[ver_raddr];
        ver_zero_reg <= (ver_raddr == '0);
    end

    `RKSE_ASSERT_IMP(a_node0_kept, node_we, node_waddr != '0)
    `RKSE_ASSERT_IMP(a_err_zero_val, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
    `RKSE_ASSERT_NXT(a_busy_after_accept, s_fire, !s_tready)
    `RKSE_ASSERT_IMP(a_pool_fits, ver_we,
        ((FW+1)'(free_reg) + (FW+1)'(need_reg)) <= (FW+1)'(NODE_POOL))

endmodule

@@ tb/kth_result_checker.sv @@
module kth_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [rkse_pkg::S_DATA_W-1:0]  s_tdata,   // value, left, right, k
    input  logic [rkse_pkg::OP_W-1:0]      s_tuser,   // op
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [rkse_pkg::M_DATA_W-1:0]  m_tdata,   // kth_value
    input  logic [rkse_pkg::STATUS_W-1:0]  m_tuser,   // status
    output int                             errors,
    output int                             waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import rkse_pkg::*;

    localparam int MAX_ITEMS   = 1024;
    localparam int VALUE_RANGE = 1024;
    localparam int NODE_POOL   = 16384;
    localparam int NODE_W      = 14;
    localparam int TALLY_W     = 11;
    localparam int PATH_NODES  = 11;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic [VALUE_W-1:0] kth_value;
        status_t            status;
    } kth_result_t;

    logic [NODE_W-1:0]  child_left   [NODE_POOL];
    logic [NODE_W-1:0]  child_right  [NODE_POOL];
    logic [TALLY_W-1:0] node_count   [NODE_POOL];
    logic [NODE_W-1:0]  version_root [MAX_ITEMS+1];
    logic [NODE_W-1:0]  next_free;
    logic [POS_W-1:0]   items_held;

    kth_result_t kth_expected [$];

    task automatic report_mismatch(string what, int expected_v, int got_v);
        if (errors < MAX_PRINTS)
            $display("[%0t] mismatch on %s: expected %0d, got %0d",
                     $time, what, expected_v, got_v);
        errors++;
    endtask

    task automatic expect_result(kth_result_t r);
        kth_expected = {kth_expected, r};
    endtask

    function automatic kth_result_t append_item(logic [VALUE_W-1:0] v);
        kth_result_t       r;
        logic [NODE_W-1:0] prev;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nxt;
        int                lo;
        int                hi;
        int                mid;
        int                vi;
        r.kth_value = '0;
        r.status    = ST_OK;
        if (items_held >= MAX_ITEMS || int'(next_free) + PATH_NODES > NODE_POOL) begin
            r.status = ST_FULL;
            return r;
        end
        vi = (int'(v) > VALUE_RANGE - 1) ? VALUE_RANGE - 1 : int'(v);
        prev = version_root[items_held];
        cur  = next_free;
        next_free++;
        version_root[items_held + 1] = cur;
        lo = 0;
        hi = VALUE_RANGE - 1;
        // copy the path down, bumping each count; the untouched side stays shared
        while (lo < hi) begin
            node_count[cur] = node_count[prev] + 1'b1;
            mid = lo + (hi - lo) / 2;
            nxt = next_free;
            next_free++;
            if (vi <= mid) begin
                child_right[cur] = child_right[prev];
                child_left[cur]  = nxt;
                prev = child_left[prev];
                hi   = mid;
            end
            else begin
                child_left[cur]  = child_left[prev];
                child_right[cur] = nxt;
                prev = child_right[prev];
                lo   = mid + 1;
            end
            cur = nxt;
        end
        node_count[cur]  = node_count[prev] + 1'b1;
        child_left[cur]  = '0;
        child_right[cur] = '0;
        items_held++;
        return r;
    endfunction

    function automatic kth_result_t query_item(logic [POS_W-1:0] l, logic [POS_W-1:0] rt,
                                               logic [POS_W-1:0] k);
        kth_result_t        r;
        logic [NODE_W-1:0]  a;
        logic [NODE_W-1:0]  b;
        logic [TALLY_W-1:0] cnt;
        logic [POS_W-1:0]   rank;
        int                 lo;
        int                 hi;
        int                 mid;
        r.kth_value = '0;
        r.status    = ST_OK;
        if (l > rt || rt > items_held || k == 0 || k > rt - l) begin
            r.status = ST_BAD_QUERY;
            return r;
        end
        a    = version_root[l];
        b    = version_root[rt];
        rank = k;
        lo   = 0;
        hi   = VALUE_RANGE - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            cnt = node_count[child_left[b]] - node_count[child_left[a]];
            if (cnt >= rank) begin
                a  = child_left[a];
                b  = child_left[b];
                hi = mid;
            end
            else begin
                rank = rank - cnt;
                a  = child_right[a];
                b  = child_right[b];
                lo = mid + 1;
            end
        end
        r.kth_value = lo[VALUE_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kth_result_t exp_r;
        if (!rst_n)
        begin
            child_left[0]   = '0;
            child_right[0]  = '0;
            node_count[0]   = '0;
            version_root[0] = '0;
            next_free       = 1;
            items_held      = '0;
            kth_expected.delete();
            errors  = 0;
            waiting <= 0;
        end
        else
        begin
            // drain before queueing so a stray result is never matched to this transaction
            if (m_tvalid && m_tready)
            begin
                if (kth_expected.size() == 0)
                    report_mismatch("result with nothing expected", 0, m_tdata);
                else
                begin
                    exp_r = kth_expected.pop_front();
                    if (m_tdata != M_DATA_W'(exp_r.kth_value))
                        report_mismatch("kth_value", exp_r.kth_value, m_tdata);
                    if (m_tuser != exp_r.status)
                        report_mismatch("status", exp_r.status, m_tuser);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (op_t'(s_tuser) == OP_APPEND)
                    expect_result(append_item(s_tdata[VALUE_LSB +: VALUE_W]));
                else
                    expect_result(query_item(s_tdata[LEFT_LSB +: POS_W],
                                             s_tdata[RIGHT_LSB +: POS_W],
                                             s_tdata[K_LSB +: POS_W]));
            end
            waiting <= kth_expected.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rkse_pkg::*;

    localparam int STORE_ITEMS = 1024;
    localparam int FIELD_MAX   = 2047;
    localparam int VALUE_MAX   = 1023;
    localparam int RANDOM_OPS  = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;   // value, left, right, k
    logic [OP_W-1:0]      s_tuser;   // op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;   // kth_value
    logic [STATUS_W-1:0]  m_tuser;   // status

    int errors;
    int waiting;
    int cycle_count = 0;
    int burst_left  = 0;
    int appends_sent = 0;
    int rx_mode   = 0;
    int mode_left = 0;

    range_kth_smallest_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    kth_result_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .waiting  (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: modes of random length, from always ready to heavy stalls
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode   <= $urandom_range(0, 3);
            mode_left <= $urandom_range(30, 300);
        end
        else
            mode_left <= mode_left - 1;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((mode_left % 8) == 0);
        endcase
    end

    function automatic int held_items();
        return (appends_sent < STORE_ITEMS) ? appends_sent : STORE_ITEMS;
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, VALUE_MAX);
            1:       return $urandom_range(0, 15);
            2:       return ($urandom_range(0, 1) != 0) ? VALUE_MAX : 0;
            default: return $urandom_range(VALUE_MAX - 15, VALUE_MAX);
        endcase
    endfunction

    task automatic send_item(op_t op, int value, int left, int right, int k);
        logic [S_DATA_W-1:0] word;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        burst_left--;
        word = '0;
        word[VALUE_LSB +: VALUE_W] = value[VALUE_W-1:0];
        word[LEFT_LSB +: POS_W]    = left[POS_W-1:0];
        word[RIGHT_LSB +: POS_W]   = right[POS_W-1:0];
        word[K_LSB +: POS_W]       = k[POS_W-1:0];
        s_tdata  <= word;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == OP_APPEND)
            appends_sent++;
    endtask

    task automatic send_append();
        send_item(OP_APPEND, rand_value(), $urandom_range(0, FIELD_MAX),
                  $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX));
    endtask

    task automatic send_good_query();
        int n;
        int l;
        int r;
        int len;
        int k;
        n = held_items();
        if (n == 0)
        begin
            send_item(OP_QUERY, $urandom_range(0, VALUE_MAX), 0, 0, 1);
            return;
        end
        case ($urandom_range(0, 3))
            0: begin r = n; l = 0; end
            1: begin r = $urandom_range(1, n); l = r - 1; end
            default: begin r = $urandom_range(1, n); l = $urandom_range(0, r - 1); end
        endcase
        len = r - l;
        case ($urandom_range(0, 3))
            0:       k = 1;
            1:       k = len;
            default: k = $urandom_range(1, len);
        endcase
        send_item(OP_QUERY, $urandom_range(0, VALUE_MAX), l, r, k);
    endtask

    task automatic send_bad_query();
        int n;
        int l;
        int r;
        int k;
        n = held_items();
        case ($urandom_range(0, 4))
            0: begin
                r = $urandom_range(0, n);
                l = r + $urandom_range(1, FIELD_MAX - r);
                k = $urandom_range(0, FIELD_MAX);
            end
            1: begin
                r = n + $urandom_range(1, FIELD_MAX - n);
                l = $urandom_range(0, r);
                k = $urandom_range(1, FIELD_MAX);
            end
            2: begin
                r = $urandom_range(0, n);
                l = $urandom_range(0, r);
                k = 0;
            end
            3: begin
                r = $urandom_range(0, n);
                l = $urandom_range(0, r);
                k = (r - l) + $urandom_range(1, FIELD_MAX - (r - l));
            end
            default: begin
                l = $urandom_range(0, FIELD_MAX);
                r = $urandom_range(0, FIELD_MAX);
                k = $urandom_range(0, FIELD_MAX);
            end
        endcase
        send_item(OP_QUERY, $urandom_range(0, VALUE_MAX), l, r, k);
    endtask

    initial
    begin
        int sel;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_APPEND;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty store, extremes, duplicates, every bad-query case
        send_item(OP_QUERY, 0, 0, 0, 0);
        send_item(OP_QUERY, VALUE_MAX, 0, 0, 1);
        send_item(OP_APPEND, 0, 0, 0, 0);
        send_item(OP_APPEND, VALUE_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
        send_item(OP_APPEND, 512, 0, 0, 0);
        send_item(OP_APPEND, 511, 0, 0, 0);
        send_item(OP_APPEND, VALUE_MAX, 0, 0, 0);
        send_item(OP_APPEND, 0, 0, 0, 0);
        send_item(OP_APPEND, 7, 0, 0, 0);
        for (int k = 1; k <= 7; k++)
            send_item(OP_QUERY, 0, 0, 7, k);
        send_item(OP_QUERY, 0, 4, 3, 1);
        send_item(OP_QUERY, 0, 0, 8, 1);
        send_item(OP_QUERY, 0, 2, 5, 0);
        send_item(OP_QUERY, 0, 2, 5, 4);
        send_item(OP_QUERY, 0, 7, 7, 1);
        send_item(OP_QUERY, VALUE_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
        send_item(OP_QUERY, 0, 0, FIELD_MAX, 1);
        send_item(OP_QUERY, 0, 3, 4, 1);
        send_item(OP_QUERY, 0, 6, 7, 1);

        repeat (RANDOM_OPS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 72)
                send_append();
            else if (sel < 92)
                send_good_query();
            else
                send_bad_query();
        end

        // fill the store, then keep appending past full
        while (appends_sent < STORE_ITEMS + 6)
        begin
            send_append();
            if ($urandom_range(0, 3) == 0)
                send_good_query();
        end
        send_item(OP_QUERY, 0, 0, STORE_ITEMS, 1);
        send_item(OP_QUERY, 0, 0, STORE_ITEMS, STORE_ITEMS);
        send_item(OP_QUERY, 0, STORE_ITEMS, STORE_ITEMS, 1);
        repeat (20)
            send_good_query();
        send_item(OP_APPEND, VALUE_MAX, 0, 0, 0);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
